// ===== design/iirdf1_pkg.sv =====
// Shared types and constants of the direct-form-I IIR filter.
// Used by iirdf1_cell, iirdf1_mac and iir_filter_direct_form_one; no dependencies.
package iirdf1_pkg;

  // Coefficients are Q8.16, so the stored word is 24 bits wide.
  localparam int COEF_WIDTH  = 24;
  localparam int TAP_CNT_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = COEF_WIDTH;
  localparam int COEF_SLOT_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FF_TAPS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FB_TAPS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_SELECT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_VALUE  = 2'd3;

  // Moves of the tap chain.
  typedef struct packed {
    logic shift_x;
    logic rotate_ff;
    logic shift_y;
    logic rotate_fb;
  } cell_ctrl_t;

  // Commands to the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic issue;
    logic use_tap;
    logic subtract;
  } mac_ctrl_t;

endpackage

// ===== design/iirdf1_cell.sv =====
// One tap of the filter chain: input and output history samples and their coefficients.
// Depends on iirdf1_pkg for the chain control struct and the coefficient width.
module iirdf1_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  iirdf1_pkg::cell_ctrl_t                    ctrl,
  input  logic                                      b_we,
  input  logic                                      a_we,
  input  logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  coef_in,
  input  logic signed [SAMPLE_WIDTH-1:0]            x_up,
  input  logic signed [SAMPLE_WIDTH-1:0]            x_down,
  input  logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  b_down,
  input  logic signed [SAMPLE_WIDTH-1:0]            y_up,
  input  logic signed [SAMPLE_WIDTH-1:0]            y_down,
  input  logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  a_down,
  output logic signed [SAMPLE_WIDTH-1:0]            x,
  output logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  b,
  output logic signed [SAMPLE_WIDTH-1:0]            y,
  output logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  a
);
  import iirdf1_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic signed [COEF_WIDTH-1:0]   b_r;
  logic signed [COEF_WIDTH-1:0]   a_r;

  // A shift moves history one tap deeper; a rotation carries the pair one tap
  // toward the head of the chain, where the shared multiplier reads it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      if (ctrl.shift_x) begin
        x_r <= x_up;
      end else if (ctrl.rotate_ff) begin
        x_r <= x_down;
      end
      if (ctrl.shift_y) begin
        y_r <= y_up;
      end else if (ctrl.rotate_fb) begin
        y_r <= y_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_r <= coef_in;
    end else if (ctrl.rotate_ff) begin
      b_r <= b_down;
    end
    if (a_we) begin
      a_r <= coef_in;
    end else if (ctrl.rotate_fb) begin
      a_r <= a_down;
    end
  end

  assign x = x_r;
  assign y = y_r;
  assign b = b_r;
  assign a = a_r;

endmodule

// ===== design/iirdf1_mac.sv =====
// Shared multiply-accumulate unit with round-half-up and output saturation.
// Depends on iirdf1_pkg for the command struct and the coefficient width.
module iirdf1_mac #(
  parameter int MAX_TAPS       = 8,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  iirdf1_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]            mul_sample,
  input  logic signed [iirdf1_pkg::COEF_WIDTH-1:0]  mul_coef,
  output logic signed [SAMPLE_WIDTH-1:0]            result,
  output logic                                      result_sat
);
  import iirdf1_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + $clog2(2 * MAX_TAPS) + 1;
  localparam int MIN_W  = COEF_FRAC_BITS + SAMPLE_WIDTH + 2;
  localparam int ACC_W  = (SUM_W > MIN_W) ? SUM_W : MIN_W;
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic                     prod_sub_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic        [ACC_W-1:0]  rnd;
  logic        [Q_W-1:0]    quot;
  logic [Q_W-SAMPLE_WIDTH:0] top_bits;
  logic                     overflow;

  assign prod_nxt = mul_sample * mul_coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.issue & ctrl.use_tap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r     <= prod_nxt;
      prod_sub_r <= ctrl.subtract;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Adding one half and dropping the fraction bits rounds halves upward.
  assign rnd      = acc_r + HALF;
  assign quot     = rnd[ACC_W-1:COEF_FRAC_BITS];
  assign top_bits = quot[Q_W-1:SAMPLE_WIDTH-1];
  assign overflow = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (overflow) begin
      result = quot[Q_W-1] ? SMIN : SMAX;
    end else begin
      result = quot[SAMPLE_WIDTH-1:0];
    end
  end
  assign result_sat = overflow;

endmodule

// ===== design/iir_filter_direct_form_one.sv =====
// Top level of the direct-form-I IIR filter: configuration registers, sequencer,
// tap chain and output register. Depends on iirdf1_pkg, iirdf1_cell and iirdf1_mac.
//
// Usage: samples enter on the in_ channel (valid/ready) and filtered samples leave
// on the out_ channel with a saturation flag, one result per input transaction.
// The cfg_ port writes the tap counts, the coefficient slot and the coefficient
// value (a write of the value stores it into the selected slot); the user must write it
// only while the filter holds no sample in flight, which the block itself does not enforce.
// Each tap of the chain holds x[n-k], y[n-1-k], b[k] and a[k]. For one sample the
// chain rotates MAX_TAPS times through the shared multiplier for the feedforward
// sum and MAX_TAPS times for the feedback sum, so the multiplier port sets the
// rate: a new sample is taken only after the previous one has passed the drain and
// done steps and the sequencer is back in idle.
// The result sits in an output register; when the receiver stalls, the next sample
// is still accepted and computed, and it waits in the final step until the register
// frees up. Reset clears both histories, the tap counts and the coefficient slot
// register; coefficients must be written before use.
module iir_filter_direct_form_one #(
  parameter int MAX_TAPS       = 8,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]          in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]          out_sample_out,
  output logic                                    out_saturated,
  input  logic                                    cfg_we,
  input  logic [iirdf1_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import iirdf1_pkg::*;

  localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CMP_W = ((CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W) + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FF    = 3'd1;
  localparam logic [2:0] ST_FB    = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [TAP_CNT_W-1:0] ff_taps_r;
  logic [TAP_CNT_W-1:0] fb_taps_r;
  logic [TAP_CNT_W-1:0] coef_sel_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_sat_r;

  logic       in_accept;
  logic       out_free;
  logic       finish;
  logic       coef_write;
  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;

  logic signed [SAMPLE_WIDTH-1:0] x_w [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] y_w [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   b_w [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   a_w [MAX_TAPS];

  logic signed [SAMPLE_WIDTH-1:0] mul_sample;
  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [SAMPLE_WIDTH-1:0] mac_result;
  logic                           mac_sat;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_taps_r  <= '0;
      fb_taps_r  <= '0;
      coef_sel_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FF_TAPS:     ff_taps_r  <= cfg_data[TAP_CNT_W-1:0];
        REG_FB_TAPS:     fb_taps_r  <= cfg_data[TAP_CNT_W-1:0];
        REG_COEF_SELECT: coef_sel_r <= cfg_data[TAP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef_write = cfg_we && (cfg_index == REG_COEF_VALUE);

  // ---------------- sequencer ----------------
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == ST_DONE) && out_free;
  assign cnt_nxt   = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = ST_FF;
      ST_FF:    if (cnt_r == CNT_LAST) state_nxt = ST_FB;
      ST_FB:    if (cnt_r == CNT_LAST) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_FF) || (state_r == ST_FB)) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cell_ctrl.shift_x   = in_accept;
    cell_ctrl.rotate_ff = (state_r == ST_FF);
    cell_ctrl.shift_y   = finish;
    cell_ctrl.rotate_fb = (state_r == ST_FB);
  end

  // The tap at the head of the chain has index cnt_r; it counts only below the
  // configured tap count, which also covers counts beyond the chain length.
  always_comb begin
    mac_ctrl.clear    = in_accept;
    mac_ctrl.issue    = (state_r == ST_FF) || (state_r == ST_FB);
    mac_ctrl.subtract = (state_r == ST_FB);
    if (state_r == ST_FB) begin
      mac_ctrl.use_tap = CMP_W'(cnt_r) < CMP_W'(fb_taps_r);
      mul_sample       = y_w[0];
      mul_coef         = a_w[0];
    end else begin
      mac_ctrl.use_tap = CMP_W'(cnt_r) < CMP_W'(ff_taps_r);
      mul_sample       = x_w[0];
      mul_coef         = b_w[0];
    end
  end

  // ---------------- tap chain ----------------
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    localparam int UP   = (k == 0) ? 0 : k - 1;
    localparam int DOWN = (k + 1) % MAX_TAPS;

    logic                           b_we;
    logic                           a_we;
    logic signed [SAMPLE_WIDTH-1:0] x_up;
    logic signed [SAMPLE_WIDTH-1:0] y_up;

    assign b_we = coef_write && !coef_sel_r[COEF_SLOT_W]
                  && (32'(coef_sel_r[COEF_SLOT_W-1:0]) == k);
    assign a_we = coef_write && coef_sel_r[COEF_SLOT_W]
                  && (32'(coef_sel_r[COEF_SLOT_W-1:0]) == k);
    assign x_up = (k == 0) ? in_sample_in : x_w[UP];
    assign y_up = (k == 0) ? mac_result : y_w[UP];

    iirdf1_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .b_we    (b_we),
      .a_we    (a_we),
      .coef_in (cfg_data),
      .x_up    (x_up),
      .x_down  (x_w[DOWN]),
      .b_down  (b_w[DOWN]),
      .y_up    (y_up),
      .y_down  (y_w[DOWN]),
      .a_down  (a_w[DOWN]),
      .x       (x_w[k]),
      .b       (b_w[k]),
      .y       (y_w[k]),
      .a       (a_w[k])
    );
  end

  // ---------------- multiply-accumulate ----------------
  iirdf1_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (mac_ctrl),
    .mul_sample (mul_sample),
    .mul_coef   (mul_coef),
    .result     (mac_result),
    .result_sat (mac_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_sample_r <= mac_result;
      out_sat_r    <= mac_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // ---------------- assertions ----------------
  a_issue_in_sums: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctrl.issue |-> ((state_r == ST_FF) || (state_r == ST_FB)))
    else $error("multiplier issued outside the tap sums");

  a_ff_to_fb: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FF) && (cnt_r == CNT_LAST)) |=> ((state_r == ST_FB) && (cnt_r == '0)))
    else $error("feedback sum did not start at tap zero");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result appeared without a finished computation");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished result not loaded into the output register");

endmodule

// ===== dv/iirdf1_tb_pkg.sv =====
// Output tracker for the direct-form-I IIR filter testbench: mirrors the filter state
// and queues the expected filtered samples. Depends on iirdf1_pkg for register indexes.
package iirdf1_tb_pkg;
  import iirdf1_pkg::*;

  localparam int FILTER_TAPS = 8;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SLOT_W      = $clog2(FILTER_TAPS);
  localparam int MAX_REPORTS = 25;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       saturated;
  } filtered_t;

  class df1_output_tracker;
    logic signed [SAMPLE_W-1:0]   x_ring [FILTER_TAPS];
    logic signed [SAMPLE_W-1:0]   y_ring [FILTER_TAPS];
    logic signed [COEF_WIDTH-1:0] b_coef [FILTER_TAPS];
    logic signed [COEF_WIDTH-1:0] a_coef [FILTER_TAPS];
    logic [SLOT_W-1:0]            x_pos;
    logic [SLOT_W-1:0]            y_pos;
    logic [TAP_CNT_W-1:0]         ff_taps;
    logic [TAP_CNT_W-1:0]         fb_taps;
    logic [TAP_CNT_W-1:0]         coef_sel;
    filtered_t                    expected_outputs [$];
    int samples_in;
    int outputs_checked;
    int outputs_saturated;
    int errors;

    function new();
      for (int i = 0; i < FILTER_TAPS; i++) begin
        x_ring[i] = '0;
        y_ring[i] = '0;
        b_coef[i] = '0;
        a_coef[i] = '0;
      end
      x_pos = '0;
      y_pos = '0;
      ff_taps = '0;
      fb_taps = '0;
      coef_sel = '0;
      samples_in = 0;
      outputs_checked = 0;
      outputs_saturated = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void apply_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_FF_TAPS:     ff_taps = data[TAP_CNT_W-1:0];
        REG_FB_TAPS:     fb_taps = data[TAP_CNT_W-1:0];
        REG_COEF_SELECT: coef_sel = data[TAP_CNT_W-1:0];
        REG_COEF_VALUE: begin
          // The top bit of the slot register picks the feedback bank.
          if (coef_sel[COEF_SLOT_W])
            a_coef[coef_sel[COEF_SLOT_W-1:0]] = data[COEF_WIDTH-1:0];
          else
            b_coef[coef_sel[COEF_SLOT_W-1:0]] = data[COEF_WIDTH-1:0];
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint            acc;
      longint            y;
      int                nb;
      int                na;
      logic [SLOT_W-1:0] pos;
      filtered_t         res;
      nb = (ff_taps > FILTER_TAPS) ? FILTER_TAPS : int'(ff_taps);
      na = (fb_taps > FILTER_TAPS) ? FILTER_TAPS : int'(fb_taps);
      samples_in++;
      x_pos = x_pos + 1'b1;
      x_ring[x_pos] = x;
      acc = 0;
      pos = x_pos;
      for (int k = 0; k < nb; k++) begin
        acc += longint'(b_coef[k]) * longint'(x_ring[pos]);
        pos = pos - 1'b1;
      end
      // The output ring still points at y[n-1] here.
      pos = y_pos;
      for (int k = 0; k < na; k++) begin
        acc -= longint'(a_coef[k]) * longint'(y_ring[pos]);
        pos = pos - 1'b1;
      end
      y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.saturated = 1'b0;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        res.saturated = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        res.saturated = 1'b1;
      end
      res.sample = y[SAMPLE_W-1:0];
      y_pos = y_pos + 1'b1;
      y_ring[y_pos] = res.sample;
      expected_outputs.push_back(res);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] sample, logic saturated);
      filtered_t want;
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("output transaction with no sample pending: sample_out %0d", sample);
        return;
      end
      want = expected_outputs.pop_front();
      outputs_checked++;
      if (want.saturated)
        outputs_saturated++;
      if (sample !== want.sample) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("sample_out: expected %0d, actual %0d", want.sample, sample);
      end
      if (saturated !== want.saturated) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
      end
    endfunction
  endclass

endpackage

// ===== dv/iir_filter_direct_form_one_tb.sv =====
// Testbench of iir_filter_direct_form_one: directed and random samples under many
// tap and coefficient settings, checked against a tracker from iirdf1_tb_pkg.
// Depends on iirdf1_pkg, iirdf1_tb_pkg and the filter RTL.
module iir_filter_direct_form_one_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iirdf1_pkg::*;
  import iirdf1_tb_pkg::*;

  localparam int PHASES         = 13;
  localparam int ITEMS_PER_PHASE = 133;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_saturated;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  df1_output_tracker tracker;
  bit                steady_phase;
  bit                hold_off_req;
  int                settings_used;

  iir_filter_direct_form_one #(
    .MAX_TAPS       (FILTER_TAPS),
    .SAMPLE_WIDTH   (SAMPLE_W),
    .COEF_FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 3) return 16'(int'($urandom_range(0, 511)) - 256);
    return 16'($urandom);
  endfunction

  function automatic logic [COEF_WIDTH-1:0] rand_coef(input int min_shift, input int max_shift);
    logic signed [COEF_WIDTH-1:0] c;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    c = 24'($urandom);
    return c >>> $urandom_range(min_shift, max_shift);
  endfunction

  function automatic int pick_taps();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return FILTER_TAPS;
      2:       return 15;
      default: return $urandom_range(1, FILTER_TAPS);
    endcase
  endfunction

  // Upper data bits beyond the register width are don't-care, so fill them randomly.
  function automatic logic [CFG_DATA_W-1:0] tap_word(input int n);
    return {20'($urandom), 4'(n)};
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected output has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic cfg_coef(input logic [3:0] sel, input logic [COEF_WIDTH-1:0] value);
    cfg_write(REG_COEF_SELECT, {20'($urandom), sel});
    cfg_write(REG_COEF_VALUE, value);
  endtask

  task automatic random_setting(input bit wild);
    int         nwrites;
    logic [3:0] sel;
    nwrites = $urandom_range(2, 16);
    repeat (nwrites) begin
      sel = 4'($urandom_range(0, 15));
      // Feedback coefficients are mostly small unless the setting should blow up.
      if (sel[COEF_SLOT_W])
        cfg_coef(sel, wild ? rand_coef(0, 12) : rand_coef(10, 16));
      else
        cfg_coef(sel, wild ? rand_coef(0, 14) : rand_coef(6, 14));
    end
    if ($urandom_range(0, 2) == 0)
      cfg_write(REG_COEF_SELECT, 24'($urandom));
    cfg_write(REG_FF_TAPS, tap_word(pick_taps()));
    cfg_write(REG_FB_TAPS, tap_word(pick_taps()));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we)
        tracker.apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready)
        tracker.note_sample(in_sample_in);
      if (out_valid && out_ready)
        tracker.check_output(out_sample_out, out_saturated);
    end
  end

  initial begin : result_sink
    int stall;
    int burst;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // One long hold-off so the output register fills and the input stalls.
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      burst = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = steady_phase ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int s;
    int waited;
    tracker = new();
    steady_phase = 1'b0;
    hold_off_req = 1'b0;
    settings_used = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_in <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both tap counts are zero after reset, so the output is zero.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle();

    // Unity gain on the first feedforward tap; every slot gets written here.
    for (s = 0; s < 16; s++)
      cfg_coef(4'(s), (s == 0) ? 24'h010000 : 24'h000000);
    cfg_write(REG_FF_TAPS, tap_word(1));
    cfg_write(REG_FB_TAPS, tap_word(0));
    cfg_we <= 1'b0;
    settings_used++;
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    settle();

    // Half gain: exact halves round toward plus infinity.
    cfg_coef(4'd0, 24'h008000);
    cfg_we <= 1'b0;
    settings_used++;
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    settle();

    // Largest and smallest coefficient against the extreme samples.
    cfg_coef(4'd0, 24'h7FFFFF);
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle();
    cfg_coef(4'd0, 24'h800000);
    cfg_we <= 1'b0;
    settings_used += 2;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle();

    // Integrator: a[0] = -1 feeds the clipped output straight back.
    cfg_coef(4'd0, 24'h010000);
    cfg_coef(4'd8, 24'hFF0000);
    cfg_write(REG_FB_TAPS, tap_word(1));
    cfg_we <= 1'b0;
    settings_used++;
    send_sample(16'sh8000);
    send_sample(16'sd1000);
    send_sample(16'sd30000);
    send_sample(16'sd30000);
    send_sample(-16'sd1);
    settle();

    // Tap counts above the ring size behave as a full ring.
    for (s = 0; s < 15; s++)
      cfg_coef(4'(s), (s < 8) ? rand_coef(4, 12) : rand_coef(12, 16));
    cfg_coef(4'd15, 24'h800000);
    cfg_write(REG_FF_TAPS, tap_word(15));
    cfg_write(REG_FB_TAPS, tap_word(9));
    cfg_we <= 1'b0;
    settings_used++;
    send_sample(rand_sample());
    send_sample(rand_sample());
    send_sample(rand_sample());

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      random_setting(phase % 3 == 0);
      steady_phase = ($urandom_range(0, 3) == 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == 10)
          hold_off_req = 1'b1;
        send_sample(rand_sample());
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * FILTER_TAPS + 6) @(posedge clk);
    if (tracker.pending() != 0)
      $error("%0d expected outputs never arrived", tracker.pending());
    $display("Summary: %0d samples under %0d filter settings, tap counts 0 to 15",
             tracker.samples_in, settings_used);
    $display("Summary: %0d outputs compared, %0d of them clipped",
             tracker.outputs_checked, tracker.outputs_saturated);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
